>>> hw/rtl/hfs_pkg.sv
// Shared types, constants and arithmetic helpers for the flux stencil block.
package hfs_pkg;

    localparam int INNER_X = 32;
    localparam int INNER_Y = 32;
    localparam int INNER_Z = 32;
    localparam int HALO = 4;
    localparam int PAD_X = INNER_X + 2 * HALO;
    localparam int PAD_Y = INNER_Y + 2 * HALO;
    localparam int PAD_Z = INNER_Z + 2 * HALO;
    localparam int WIN_PLANES = 8;
    localparam int PLANE_SZ = PAD_Y * PAD_Z;
    localparam int WIN_DEPTH = WIN_PLANES * PLANE_SZ;
    localparam int ADDR_W = $clog2(WIN_DEPTH);
    localparam int POS_W = 6;
    localparam int ACC_W = 52;
    localparam int PROD_W = 48;

    localparam logic [2:0] REG_COEF_ONE = 3'd0;
    localparam logic [2:0] REG_COEF_TWO = 3'd1;
    localparam logic [2:0] REG_COEF_THREE = 3'd2;
    localparam logic [2:0] REG_COEF_FOUR = 3'd3;
    localparam logic [2:0] REG_INV_X = 3'd4;
    localparam logic [2:0] REG_INV_Y = 3'd5;
    localparam logic [2:0] REG_INV_Z = 3'd6;

    typedef struct packed {
        logic signed [31:0] momentum_x;
        logic signed [31:0] momentum_y;
        logic signed [31:0] momentum_z;
        logic signed [31:0] total_energy;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic signed [31:0] pressure_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] flux_mass;
        logic signed [31:0] flux_mom_x;
        logic signed [31:0] flux_mom_y;
        logic signed [31:0] flux_mom_z;
        logic signed [31:0] flux_energy;
        logic               last_point;
    } t_out_item;

    // Field n of a point sits at index n.
    typedef logic [7:0][31:0] t_point;

    typedef struct packed {
        logic [3:0][31:0] coef;
        logic [2:0][31:0] inv;
    } t_cfg;

    typedef struct packed {
        t_point           pt;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic             interior;
        logic             last;
    } t_job;

    function automatic t_point to_point(input t_in_item it);
        t_point p;
        p[0] = it.momentum_x;
        p[1] = it.momentum_y;
        p[2] = it.momentum_z;
        p[3] = it.total_energy;
        p[4] = it.velocity_x;
        p[5] = it.velocity_y;
        p[6] = it.velocity_z;
        p[7] = it.pressure_in;
        return p;
    endfunction

    // Q16.16 product, floor rounding.
    function automatic logic signed [PROD_W-1:0] fmul(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [63:0] pr;
        pr = a * b;
        return PROD_W'(pr >>> 16);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi) return 32'h7fffffff;
        if (v < lo) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [ADDR_W-1:0] win_addr(input logic [2:0] plane,
                                                   input logic [POS_W-1:0] y,
                                                   input logic [POS_W-1:0] z);
        return ADDR_W'(plane) * ADDR_W'(PLANE_SZ) + ADDR_W'(y) * ADDR_W'(PAD_Z)
               + ADDR_W'(z);
    endfunction

endpackage

>>> hw/rtl/hfs_ram.sv
// Generic simple dual-port RAM with registered read.
module hfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/hfs_front.sv
// Front end: tracks raster position, classifies points, queues jobs.
module hfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hfs_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_job_valid,
    output hfs_pkg::t_job     o_job,
    input  logic              i_job_pop
);
    import hfs_pkg::*;

    logic [POS_W-1:0] r_x, r_y, r_z;
    t_job             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             acc_in;
    logic [POS_W-1:0] cx;
    t_job             job;

    assign o_full = (r_cnt == 2'd2);
    assign acc_in = i_push && !o_full;
    assign cx = r_x - POS_W'(4);

    always_comb begin
        job.pt = to_point(i_item);
        job.x = r_x;
        job.y = r_y;
        job.z = r_z;
        job.interior = (r_x >= POS_W'(4)) && (cx >= POS_W'(HALO))
                       && (cx < POS_W'(HALO + INNER_X))
                       && (r_y >= POS_W'(HALO)) && (r_y < POS_W'(HALO + INNER_Y))
                       && (r_z >= POS_W'(HALO)) && (r_z < POS_W'(HALO + INNER_Z));
        job.last = (cx == POS_W'(HALO + INNER_X - 1)) && (r_y == POS_W'(HALO + INNER_Y - 1))
                   && (r_z == POS_W'(HALO + INNER_Z - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (acc_in) begin
                r_wp <= !r_wp;
                // advance raster position, z fastest
                if (r_z == POS_W'(PAD_Z - 1)) begin
                    r_z <= '0;
                    if (r_y == POS_W'(PAD_Y - 1)) begin
                        r_y <= '0;
                        r_x <= (r_x == POS_W'(PAD_X - 1)) ? '0 : r_x + POS_W'(1);
                    end else begin
                        r_y <= r_y + POS_W'(1);
                    end
                end else begin
                    r_z <= r_z + POS_W'(1);
                end
            end
            if (i_job_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(acc_in) - 2'(i_job_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_q[r_wp] <= job;
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];
endmodule

>>> hw/rtl/hfs_back.sv
// Back end: window store, neighbor read sequencer and flux datapath.
module hfs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hfs_pkg::t_cfg      i_cfg,
    input  logic               i_job_valid,
    input  hfs_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    output hfs_pkg::t_out_item o_result,
    input  logic               i_pop
);
    import hfs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0]        r_state;
    logic [4:0]        r_k;
    logic              r_rd_v;
    logic [4:0]        r_rd_k;
    t_point            r_p;
    logic              r_done;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              r_s1_v, r_s2_v, r_s3_v, r_s5_v, r_s6_v;
    logic [1:0]        r_s1_ax, r_s2_ax, r_s3_ax, r_s5_ax, r_s6_ax;
    logic [1:0]        r_s1_d, r_s2_d, r_s3_d;
    logic signed [PROD_W-1:0] r_pp [5];
    logic signed [PROD_W-1:0] r_mp [5];
    logic signed [32:0] r_dm, r_dp;
    logic signed [31:0] r_b [5];
    logic signed [PROD_W-1:0] r_c [5];
    logic signed [ACC_W-1:0]  r_s [5];
    logic signed [31:0] r_ss [5];
    logic signed [PROD_W-1:0] r_ip [5];
    logic signed [ACC_W-1:0]  r_acc [5];

    t_point            rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic              can_write;
    logic [1:0]        k_ax, k_d;
    logic [2:0]        dd;
    logic [POS_W-1:0]  cx, px, py, pz;
    logic [1:0]        rax;
    logic signed [31:0] pu, mu, coef, inv;
    logic signed [ACC_W-1:0] n_s [5];

    hfs_ram #(.WIDTH(256), .DEPTH(WIN_DEPTH)) u_win (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (win_addr(i_job.x[2:0], i_job.y, i_job.z)),
        .i_wdata (i_job.pt),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Read order: per axis, per distance, plus side then minus side.
    assign k_ax = r_k[4:3];
    assign k_d = r_k[2:1];
    assign dd = {1'b0, k_d} + 3'd1;
    assign cx = i_job.x - POS_W'(4);

    always_comb begin
        px = cx;
        py = i_job.y;
        pz = i_job.z;
        case (k_ax)
            2'd0: px = r_k[0] ? cx - POS_W'(dd) : cx + POS_W'(dd);
            2'd1: py = r_k[0] ? i_job.y - POS_W'(dd) : i_job.y + POS_W'(dd);
            default: pz = r_k[0] ? i_job.z - POS_W'(dd) : i_job.z + POS_W'(dd);
        endcase
        rd_addr = win_addr(px[2:0], py, pz);
    end

    assign can_write = !i_job.interior || !r_out_valid || i_pop;
    assign we = (r_state == S_WRITE) && can_write;
    assign o_job_pop = we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k <= '0;
            r_rd_v <= 1'b0;
            r_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_ISSUE);
            if (r_s6_v && r_s6_ax == 2'd2) begin
                r_done <= 1'b1;
            end
            // hold the result until popped, load a new one on an interior write
            r_out_valid <= (r_out_valid && !i_pop) || (we && i_job.interior);
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (i_job_valid) begin
                        r_state <= i_job.interior ? S_ISSUE : S_WRITE;
                    end
                end
                S_ISSUE: begin
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'd23) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (can_write) begin
                        r_done <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        if (we && i_job.interior) begin
            r_out.flux_mass <= sat32(-r_acc[0]);
            r_out.flux_mom_x <= sat32(-r_acc[1]);
            r_out.flux_mom_y <= sat32(-r_acc[2]);
            r_out.flux_mom_z <= sat32(-r_acc[3]);
            r_out.flux_energy <= sat32(-r_acc[4]);
            r_out.last_point <= i_job.last;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_result = r_out;

    // Stage 1: velocity products of both neighbors.
    assign rax = r_rd_k[4:3];
    assign pu = r_p[{1'b1, rax}];
    assign mu = rd_data[{1'b1, rax}];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            r_s1_v <= r_rd_v && r_rd_k[0];
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s5_v <= r_s3_v && (r_s3_d == 2'd3);
            r_s6_v <= r_s5_v;
        end
    end

    always_comb begin
        coef = i_cfg.coef[r_s2_d];
        case (r_s5_ax)
            2'd0: inv = i_cfg.inv[0];
            2'd1: inv = i_cfg.inv[1];
            default: inv = i_cfg.inv[2];
        endcase
        for (int n = 0; n < 5; n++) begin
            n_s[n] = (r_s3_d == 2'd0) ? ACC_W'(r_c[n]) : r_s[n] + ACC_W'(r_c[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v && !r_rd_k[0]) begin
            // the plus-four x neighbor is the arriving point itself
            r_p <= (r_rd_k[4:1] == 4'd3) ? i_job.pt : rd_data;
        end
        if (r_rd_v && r_rd_k[0]) begin
            r_s1_ax <= rax;
            r_s1_d <= r_rd_k[2:1];
            for (int n = 0; n < 4; n++) begin
                r_pp[n] <= fmul(r_p[n], pu);
                r_mp[n] <= fmul(rd_data[n], mu);
            end
            r_pp[4] <= fmul(r_p[7], pu);
            r_mp[4] <= fmul(rd_data[7], mu);
            r_dm <= 33'($signed(r_p[{1'b0, rax}])) - 33'($signed(rd_data[{1'b0, rax}]));
            r_dp <= 33'($signed(r_p[7])) - 33'($signed(rd_data[7]));
        end
        // Stage 2: saturated brackets.
        r_s2_ax <= r_s1_ax;
        r_s2_d <= r_s1_d;
        r_b[0] <= sat32(ACC_W'(r_dm));
        for (int n = 0; n < 3; n++) begin
            r_b[n+1] <= sat32(ACC_W'(r_pp[n]) - ACC_W'(r_mp[n])
                              + ((2'(n) == r_s1_ax) ? ACC_W'(r_dp) : '0));
        end
        r_b[4] <= sat32(ACC_W'(r_pp[3]) - ACC_W'(r_mp[3]) + ACC_W'(r_pp[4])
                        - ACC_W'(r_mp[4]));
        // Stage 3: weight by distance.
        r_s3_ax <= r_s2_ax;
        r_s3_d <= r_s2_d;
        for (int n = 0; n < 5; n++) begin
            r_c[n] <= fmul(coef, r_b[n]);
        end
        // Stage 4: sum over distances, saturate at the axis end.
        if (r_s3_v) begin
            r_s5_ax <= r_s3_ax;
            for (int n = 0; n < 5; n++) begin
                r_s[n] <= n_s[n];
                r_ss[n] <= sat32(n_s[n]);
            end
        end
        // Stage 5: scale by inverse spacing.
        r_s6_ax <= r_s5_ax;
        for (int n = 0; n < 5; n++) begin
            r_ip[n] <= fmul(r_ss[n], inv);
        end
        // Stage 6: sum over axes.
        if (r_s6_v) begin
            for (int n = 0; n < 5; n++) begin
                r_acc[n] <= (r_s6_ax == 2'd0) ? ACC_W'(r_ip[n]) : r_acc[n] + ACC_W'(r_ip[n]);
            end
        end
    end
endmodule

>>> hw/rtl/hyperbolic_flux_stencil.sv
// Interior point: dispatch, 24 window reads through the single window read port,
// pipeline drain and window write. Halo point: dispatch and window write.
// 2-entry job queue, 1 result register. Synchronous active-low reset clears
// position, queues and restores the default coefficients; window contents are
// undefined until written.
module hyperbolic_flux_stencil (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  hfs_pkg::t_in_item  i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output hfs_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import hfs_pkg::*;

    t_cfg r_cfg;
    logic job_valid, job_pop;
    t_job job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef[0] <= 32'sd52429;
            r_cfg.coef[1] <= -32'sd13107;
            r_cfg.coef[2] <= 32'sd2497;
            r_cfg.coef[3] <= -32'sd234;
            r_cfg.inv[0] <= 32'sd65536;
            r_cfg.inv[1] <= 32'sd65536;
            r_cfg.inv[2] <= 32'sd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COEF_ONE: r_cfg.coef[0] <= i_cfg_data;
                REG_COEF_TWO: r_cfg.coef[1] <= i_cfg_data;
                REG_COEF_THREE: r_cfg.coef[2] <= i_cfg_data;
                REG_COEF_FOUR: r_cfg.coef[3] <= i_cfg_data;
                REG_INV_X: r_cfg.inv[0] <= i_cfg_data;
                REG_INV_Y: r_cfg.inv[1] <= i_cfg_data;
                REG_INV_Z: r_cfg.inv[2] <= i_cfg_data;
                default: ; // drop writes past the register list
            endcase
        end
    end

    hfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    hfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .o_result    (o_result),
        .i_pop       (pop)
    );
endmodule

>>> tb/hfs_flux_checker.sv
// Watches the stencil block's channels, predicts the flux results and compares them.
module hfs_flux_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  hfs_pkg::t_in_item  i_item,
    input  logic               empty,
    input  logic               pop,
    input  hfs_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);
    import hfs_pkg::*;

    longint plane_store [WIN_DEPTH][8];
    longint coef [4];
    longint inv_step [3];
    longint pp [4][8];
    longint mm [4][8];
    longint acc [5];
    int px, py, pz;
    t_out_item flux_queue [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, floor rounding
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    task automatic fetch(input bit plus, input int d, input int pl, input int y, input int z);
        int idx;
        idx = ((pl % WIN_PLANES) * PAD_Y + y) * PAD_Z + z;
        for (int f = 0; f < 8; f++) begin
            if (plus) pp[d][f] = plane_store[idx][f];
            else mm[d][f] = plane_store[idx][f];
        end
    endtask

    task automatic add_axis(input int a, input longint inv);
        longint s [5];
        longint b [5];
        longint pu, mu;
        for (int n = 0; n < 5; n++) s[n] = 0;
        for (int d = 0; d < 4; d++) begin
            pu = pp[d][4 + a];
            mu = mm[d][4 + a];
            b[0] = pp[d][a] - mm[d][a];
            for (int n = 0; n < 3; n++) begin
                b[1 + n] = qmul(pp[d][n], pu) - qmul(mm[d][n], mu);
                if (n == a) b[1 + n] += pp[d][7] - mm[d][7];
            end
            b[4] = qmul(pp[d][3], pu) - qmul(mm[d][3], mu)
                   + qmul(pp[d][7], pu) - qmul(mm[d][7], mu);
            for (int n = 0; n < 5; n++) s[n] += qmul(coef[d], clamp32(b[n]));
        end
        for (int n = 0; n < 5; n++) acc[n] += qmul(clamp32(s[n]), inv);
    endtask

    task automatic take_point(input t_in_item it);
        longint cur [8];
        int cx, idx;
        t_out_item r;
        cur[0] = longint'($signed(it.momentum_x));
        cur[1] = longint'($signed(it.momentum_y));
        cur[2] = longint'($signed(it.momentum_z));
        cur[3] = longint'($signed(it.total_energy));
        cur[4] = longint'($signed(it.velocity_x));
        cur[5] = longint'($signed(it.velocity_y));
        cur[6] = longint'($signed(it.velocity_z));
        cur[7] = longint'($signed(it.pressure_in));
        cx = px - 4;
        if (px >= 4 && cx >= HALO && cx < HALO + INNER_X && py >= HALO
            && py < HALO + INNER_Y && pz >= HALO && pz < HALO + INNER_Z) begin
            for (int n = 0; n < 5; n++) acc[n] = 0;
            // the arriving point is the +4 neighbor along x
            for (int d = 0; d < 4; d++) begin
                if (d == 3) begin
                    for (int f = 0; f < 8; f++) pp[3][f] = cur[f];
                end else begin
                    fetch(1, d, cx + d + 1, py, pz);
                end
                fetch(0, d, cx - d - 1, py, pz);
            end
            add_axis(0, inv_step[0]);
            for (int d = 0; d < 4; d++) begin
                fetch(1, d, cx, py + d + 1, pz);
                fetch(0, d, cx, py - d - 1, pz);
            end
            add_axis(1, inv_step[1]);
            for (int d = 0; d < 4; d++) begin
                fetch(1, d, cx, py, pz + d + 1);
                fetch(0, d, cx, py, pz - d - 1);
            end
            add_axis(2, inv_step[2]);
            r.flux_mass   = 32'(clamp32(-acc[0]));
            r.flux_mom_x  = 32'(clamp32(-acc[1]));
            r.flux_mom_y  = 32'(clamp32(-acc[2]));
            r.flux_mom_z  = 32'(clamp32(-acc[3]));
            r.flux_energy = 32'(clamp32(-acc[4]));
            r.last_point  = (cx == HALO + INNER_X - 1 && py == HALO + INNER_Y - 1
                             && pz == HALO + INNER_Z - 1);
            flux_queue.push_back(r);
        end
        idx = ((px % WIN_PLANES) * PAD_Y + py) * PAD_Z + pz;
        for (int f = 0; f < 8; f++) plane_store[idx][f] = cur[f];
        // advance raster position, z fastest
        pz++;
        if (pz >= PAD_Z) begin
            pz = 0;
            py++;
            if (py >= PAD_Y) begin
                py = 0;
                px++;
                if (px >= PAD_X) px = 0;
            end
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (flux_queue.size() == 0) begin
            $error("unexpected flux result: mass %0d", $signed(got.flux_mass));
            o_errors++;
        end else begin
            want = flux_queue.pop_front();
            o_checked++;
            check_field("flux_mass", $signed(want.flux_mass), $signed(got.flux_mass));
            check_field("flux_mom_x", $signed(want.flux_mom_x), $signed(got.flux_mom_x));
            check_field("flux_mom_y", $signed(want.flux_mom_y), $signed(got.flux_mom_y));
            check_field("flux_mom_z", $signed(want.flux_mom_z), $signed(got.flux_mom_z));
            check_field("flux_energy", $signed(want.flux_energy),
                        $signed(got.flux_energy));
            check_field("last_point", want.last_point, got.last_point);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors = 0;
            o_checked = 0;
            px = 0;
            py = 0;
            pz = 0;
            coef[0] = 52429;
            coef[1] = -13107;
            coef[2] = 2497;
            coef[3] = -234;
            for (int a = 0; a < 3; a++) inv_step[a] = 65536;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < REG_INV_X)
                    coef[i_cfg_index] = longint'($signed(i_cfg_data));
                else if (i_cfg_index <= REG_INV_Z)
                    inv_step[i_cfg_index - REG_INV_X] = longint'($signed(i_cfg_data));
            end
            if (push && !full) take_point(i_item);
            if (pop && !empty) check_result(o_result);
        end
        o_pending = flux_queue.size();
    end
endmodule

>>> tb/tb_hyperbolic_flux_stencil.sv
// Testbench top: drives grid points and register writes, gives the verdict.
module tb_hyperbolic_flux_stencil;
    import hfs_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int POINTS = 16000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, o_cfg_ready;
    t_in_item i_item = '0;
    t_out_item o_result;
    logic i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = REG_COEF_ONE;
    logic [31:0] i_cfg_data = '0;
    int errors, pending, checked;
    int send_idle = 25;
    int recv_idle = 76;
    int stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    hyperbolic_flux_stencil dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    hfs_flux_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= recv_idle);
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [31:0] corner_word(input int k);
        case (k % 6)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return 32'h00010000;
            default: return 32'h1;
        endcase
    endfunction

    // modest values half of the time so that not every flux saturates
    function automatic logic [31:0] field_word();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) return 32'($urandom_range(524287)) - 32'd262144;
        if (pick == 5) return corner_word($urandom_range(5));
        return $urandom();
    endfunction

    function automatic t_in_item make_point(input int n);
        t_in_item it;
        if (n < 25) begin
            it.momentum_x   = corner_word(n);
            it.momentum_y   = corner_word(n + 1);
            it.momentum_z   = corner_word(n + 2);
            it.total_energy = corner_word(n + 3);
            it.velocity_x   = corner_word(n + 4);
            it.velocity_y   = corner_word(n + 5);
            it.velocity_z   = corner_word(n / 6);
            it.pressure_in  = corner_word(n + n / 6);
        end else begin
            it.momentum_x   = field_word();
            it.momentum_y   = field_word();
            it.momentum_z   = field_word();
            it.total_energy = field_word();
            it.velocity_x   = field_word();
            it.velocity_y   = field_word();
            it.velocity_z   = field_word();
            it.pressure_in  = field_word();
        end
        return it;
    endfunction

    task automatic send_point(input t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    // hold valid high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // out-of-range index must be dropped
        write_reg(3'd7, 32'h12345678);
        i_cfg_valid <= 1'b0;
        for (int n = 0; n < POINTS; n++) begin
            if (n == 13000) begin
                drain();
                write_reg(REG_COEF_ONE, 32'h7fffffff);
                write_reg(REG_COEF_TWO, 32'h80000000);
                write_reg(REG_COEF_THREE, $urandom());
                write_reg(REG_COEF_FOUR, 32'h0);
                write_reg(REG_INV_X, 32'h80000000);
                write_reg(REG_INV_Y, 32'h7fffffff);
                write_reg(REG_INV_Z, 32'h1);
                i_cfg_valid <= 1'b0;
                send_idle = 76;
                recv_idle = 25;
            end else if (n == 14400) begin
                drain();
                write_reg(REG_COEF_ONE, 32'($urandom_range(131071)) - 32'd65536);
                write_reg(REG_COEF_TWO, 32'($urandom_range(131071)) - 32'd65536);
                write_reg(REG_COEF_THREE, 32'($urandom_range(131071)) - 32'd65536);
                write_reg(REG_COEF_FOUR, 32'($urandom_range(131071)) - 32'd65536);
                write_reg(REG_INV_X, 32'($urandom_range(262143)) - 32'd131072);
                write_reg(REG_INV_Y, 32'($urandom_range(262143)) - 32'd131072);
                write_reg(REG_INV_Z, 32'($urandom_range(262143)) - 32'd131072);
                i_cfg_valid <= 1'b0;
                send_idle = 0;
                recv_idle = 0;
            end
            send_point(make_point(n));
        end
        drain();
        $display("streamed %0d grid points through ten x-planes, checked %0d flux results",
                 POINTS, checked);
        $display("under default, extreme and random coefficient and spacing registers");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
